FILE: sv/cbpm_pkg.sv
// ----------------------------------------------------------------------------
// cbpm_pkg
// Shared codes and field widths for the buffer pool clock replacement block.
// ----------------------------------------------------------------------------
package cbpm_pkg;

  localparam int unsigned PageIdW = 32;
  localparam int unsigned FrameW  = 4;
  localparam int unsigned StatusW = 2;

  localparam logic OP_GET     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK         = 2'd0;
  localparam logic [StatusW-1:0] STATUS_ALL_PINNED = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_PINNED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    MODE_RELEASE,
    MODE_LOOKUP,
    MODE_SWEEP
  } mode_e;

endpackage

FILE: sv/cbpm_if.sv
// ----------------------------------------------------------------------------
// cbpm_req_if / cbpm_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbpm_req_if
  import cbpm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [PageIdW-1:0] page_id;
  logic [FrameW-1:0]  frame_index;
  logic               mark_dirty;

  modport source (output valid, operation, page_id, frame_index, mark_dirty,
                  input ready);
  modport sink   (input valid, operation, page_id, frame_index, mark_dirty,
                  output ready);
endinterface

interface cbpm_rsp_if
  import cbpm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FrameW-1:0]  frame;
  logic               hit;
  logic               fetch_needed;
  logic               writeback_needed;
  logic [PageIdW-1:0] evicted_page;
  logic [StatusW-1:0] status;

  modport source (output valid, frame, hit, fetch_needed, writeback_needed,
                  evicted_page, status, input ready);
  modport sink   (input valid, frame, hit, fetch_needed, writeback_needed,
                  evicted_page, status, output ready);
endinterface

FILE: sv/clock_buffer_pool_manager_top.sv
// ----------------------------------------------------------------------------
// clock_buffer_pool_manager_top
// Buffer frame manager with clock replacement over a frame state memory.
// ----------------------------------------------------------------------------
// Sequencing: a rejected release or a get into an empty pool goes straight to
//   the response state; a release reads and updates its frame; a get reads
//   frames one at a time (resident scan, then up to 2*FRAMES clock sweep steps).
// Throughput: one request at a time; each frame is read in ST_READ and evaluated
//   in ST_EVAL; the next request is accepted the cycle after the result loads.
// Reset: asynchronous; fill count and clock hand clear, no memory sweep.
// ----------------------------------------------------------------------------
module clock_buffer_pool_manager_top
  import cbpm_pkg::*;
#(
  parameter int unsigned FRAMES       = 16,
  parameter int unsigned PAGE_ID_BITS = 32,
  parameter int unsigned PIN_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbpm_req_if.sink    req_i,
  cbpm_rsp_if.source  rsp_o
);

  localparam int unsigned FW   = $clog2(FRAMES);
  localparam int unsigned CW   = FW + 2;
  localparam int unsigned TW   = PAGE_ID_BITS;
  localparam int unsigned MW   = TW + PIN_BITS + 2;
  localparam int unsigned LastStep = 2 * FRAMES - 1;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  logic [TW-1:0]       page_q, page_d;
  logic                mark_q, mark_d;
  logic [FW-1:0]       addr_q, addr_d;
  logic [FW-1:0]       hand_q, hand_d;
  logic [FW:0]         fill_q, fill_d;
  logic [CW-1:0]       cnt_q, cnt_d;

  // result being built and output register
  logic [FrameW-1:0]   r_frame_q, r_frame_d;
  logic                r_hit_q, r_hit_d;
  logic                r_fetch_q, r_fetch_d;
  logic                r_wb_q, r_wb_d;
  logic [PageIdW-1:0]  r_evict_q, r_evict_d;
  logic [StatusW-1:0]  r_status_q, r_status_d;
  logic                out_valid_q;

  // memory ports
  logic                we;
  logic [FW-1:0]       waddr;
  logic [MW-1:0]       wdata;
  logic                re;
  logic [MW-1:0]       rdata;

  logic [TW-1:0]       rd_tag;
  logic                rd_ref;
  logic [PIN_BITS-1:0] rd_pin;
  logic                rd_dirty;

  logic                accept;
  logic                rel_bad;
  logic                tag_match;
  logic                last_resident;
  logic                fill_full;
  logic                last_step;
  logic                rel_empty;
  logic                sweep_take;
  logic [FW-1:0]       addr_next;
  logic                out_load;
  logic [MW-1:0]       install_word;

  cbpm_frame_mem #(
    .Depth (FRAMES),
    .Width (MW),
    .AddrW (FW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign {rd_tag, rd_ref, rd_pin, rd_dirty} = rdata;

  assign accept        = req_i.valid && req_i.ready;
  assign rel_bad       = (32'(req_i.frame_index) >= 32'(FRAMES))
                      || (32'(req_i.frame_index) >= 32'(fill_q));
  assign tag_match     = (rd_tag == page_q);
  assign last_resident = ((FW+1)'(addr_q) + (FW+1)'(1)) == fill_q;
  assign fill_full     = (fill_q == (FW+1)'(FRAMES));
  assign last_step     = (cnt_q == CW'(LastStep));
  assign rel_empty     = (rd_pin == '0);
  assign sweep_take    = !rd_ref && (rd_pin == '0);
  assign addr_next     = (32'(addr_q) == FRAMES - 1) ? '0 : addr_q + FW'(1);
  assign out_load      = (state_q == ST_RESP) && (!out_valid_q || rsp_o.ready);
  assign install_word  = {page_q, 1'b1, PIN_BITS'(1), 1'b0};

  assign req_i.ready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.operation == OP_RELEASE) begin
            state_d = rel_bad ? ST_RESP : ST_READ;
          end else begin
            state_d = (fill_q == '0) ? ST_RESP : ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        unique case (mode_q)
          MODE_RELEASE: state_d = ST_RESP;
          MODE_LOOKUP: begin
            if (tag_match || (last_resident && !fill_full)) begin
              state_d = ST_RESP;
            end else begin
              state_d = ST_READ;
            end
          end
          MODE_SWEEP: begin
            if (sweep_take || last_step) begin
              state_d = ST_RESP;
            end else begin
              state_d = ST_READ;
            end
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_d     = mode_q;
    page_d     = page_q;
    mark_d     = mark_q;
    addr_d     = addr_q;
    hand_d     = hand_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    r_frame_d  = r_frame_q;
    r_hit_d    = r_hit_q;
    r_fetch_d  = r_fetch_q;
    r_wb_d     = r_wb_q;
    r_evict_d  = r_evict_q;
    r_status_d = r_status_q;
    we         = 1'b0;
    waddr      = addr_q;
    wdata      = rdata;
    re         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          page_d     = TW'(req_i.page_id);
          mark_d     = req_i.mark_dirty;
          addr_d     = '0;
          cnt_d      = '0;
          r_frame_d  = '0;
          r_hit_d    = 1'b0;
          r_fetch_d  = 1'b0;
          r_wb_d     = 1'b0;
          r_evict_d  = '0;
          r_status_d = STATUS_OK;
          if (req_i.operation == OP_RELEASE) begin
            mode_d    = MODE_RELEASE;
            addr_d    = FW'(req_i.frame_index);
            r_frame_d = req_i.frame_index;
            if (rel_bad) begin
              r_status_d = STATUS_NOT_PINNED;
            end
          end else begin
            mode_d = MODE_LOOKUP;
            if (fill_q == '0) begin
              // empty pool: install straight into frame 0
              we        = 1'b1;
              waddr     = '0;
              wdata     = {TW'(req_i.page_id), 1'b1, PIN_BITS'(1), 1'b0};
              fill_d    = (FW+1)'(1);
              r_fetch_d = 1'b1;
            end
          end
        end
      end
      ST_READ: re = 1'b1;
      ST_EVAL: begin
        unique case (mode_q)
          MODE_RELEASE: begin
            if (rel_empty) begin
              r_status_d = STATUS_NOT_PINNED;
            end else begin
              we    = 1'b1;
              wdata = {rd_tag, rd_ref, rd_pin - PIN_BITS'(1), rd_dirty | mark_q};
            end
          end
          MODE_LOOKUP: begin
            if (tag_match) begin
              we        = 1'b1;
              wdata     = {rd_tag, 1'b1, (&rd_pin) ? rd_pin : rd_pin + PIN_BITS'(1),
                           rd_dirty};
              r_frame_d = FrameW'(addr_q);
              r_hit_d   = 1'b1;
            end else if (last_resident && !fill_full) begin
              we        = 1'b1;
              waddr     = FW'(fill_q);
              wdata     = install_word;
              fill_d    = fill_q + (FW+1)'(1);
              r_frame_d = FrameW'(fill_q);
              r_fetch_d = 1'b1;
            end else if (last_resident) begin
              // all frames used: start the clock sweep one past the hand
              mode_d = MODE_SWEEP;
              hand_d = (32'(hand_q) == FRAMES - 1) ? '0 : hand_q + FW'(1);
              addr_d = (32'(hand_q) == FRAMES - 1) ? '0 : hand_q + FW'(1);
            end else begin
              addr_d = addr_next;
            end
          end
          MODE_SWEEP: begin
            if (rd_ref) begin
              we    = 1'b1;
              wdata = {rd_tag, 1'b0, rd_pin, rd_dirty};
            end
            if (sweep_take) begin
              we        = 1'b1;
              wdata     = install_word;
              r_frame_d = FrameW'(addr_q);
              r_fetch_d = 1'b1;
              r_wb_d    = rd_dirty;
              r_evict_d = PageIdW'(rd_tag);
            end else if (last_step) begin
              r_status_d = STATUS_ALL_PINNED;
            end else begin
              cnt_d  = cnt_q + CW'(1);
              hand_d = addr_next;
              addr_d = addr_next;
            end
          end
          default: ;
        endcase
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_LOOKUP;
      hand_q      <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      hand_q  <= hand_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_d_hold: begin
      page_q     <= page_d;
      mark_q     <= mark_d;
      addr_q     <= addr_d;
      r_frame_q  <= r_frame_d;
      r_hit_q    <= r_hit_d;
      r_fetch_q  <= r_fetch_d;
      r_wb_q     <= r_wb_d;
      r_evict_q  <= r_evict_d;
      r_status_q <= r_status_d;
    end
  end

  // output beat register
  logic [FrameW-1:0]  o_frame_q;
  logic               o_hit_q;
  logic               o_fetch_q;
  logic               o_wb_q;
  logic [PageIdW-1:0] o_evict_q;
  logic [StatusW-1:0] o_status_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_frame_q  <= r_frame_q;
      o_hit_q    <= r_hit_q;
      o_fetch_q  <= r_fetch_q;
      o_wb_q     <= r_wb_q;
      o_evict_q  <= r_evict_q;
      o_status_q <= r_status_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.frame            = o_frame_q;
  assign rsp_o.hit              = o_hit_q;
  assign rsp_o.fetch_needed     = o_fetch_q;
  assign rsp_o.writeback_needed = o_wb_q;
  assign rsp_o.evicted_page     = o_evict_q;
  assign rsp_o.status           = o_status_q;

endmodule

FILE: sv/cbpm_frame_mem.sv
// ----------------------------------------------------------------------------
// cbpm_frame_mem
// Per-frame state store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbpm_frame_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 42,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: tb/tb_clock_buffer_pool_manager_top.sv
// ----------------------------------------------------------------------------
// tb_clock_buffer_pool_manager_top
// Self-checking bench for the buffer pool clock replacement block: a queued
// driver feeds get and release requests with random gaps, a shadow model of
// the frame table predicts each response, and a monitor compares field by
// field under random backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_clock_buffer_pool_manager_top;
  import cbpm_pkg::*;

  localparam int unsigned NFRAMES = 16;
  localparam int unsigned PIN_MAX = 255;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic               operation;
    logic [PageIdW-1:0] page_id;
    logic [FrameW-1:0]  frame_index;
    logic               mark_dirty;
  } req_t;

  typedef struct packed {
    logic [FrameW-1:0]  frame;
    logic               hit;
    logic               fetch_needed;
    logic               writeback_needed;
    logic [PageIdW-1:0] evicted_page;
    logic [StatusW-1:0] status;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  cbpm_req_if req_bus ();
  cbpm_rsp_if rsp_bus ();

  clock_buffer_pool_manager_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  // shadow frame table
  logic [PageIdW-1:0] tag_q [NFRAMES];
  logic               valid_q [NFRAMES];
  logic               refb_q [NFRAMES];
  logic [7:0]         pins_q [NFRAMES];
  logic               dirty_q [NFRAMES];
  logic [FrameW-1:0]  hand_q;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   errors;
  int   idle_cycles;
  bit   hold_send;
  bit   no_idle;
  logic [PageIdW-1:0] page_pool [8];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic rsp_t predict_frame_grant(req_t r);
    rsp_t o;
    int   f;
    o = '0;
    if (r.operation == OP_RELEASE) begin
      o.frame = r.frame_index;
      if (pins_q[r.frame_index] == 0) begin
        o.status = STATUS_NOT_PINNED;
        return o;
      end
      pins_q[r.frame_index]--;
      if (r.mark_dirty) dirty_q[r.frame_index] = 1'b1;
      o.status = STATUS_OK;
      return o;
    end
    for (f = 0; f < NFRAMES; f++) begin
      if (valid_q[f] && tag_q[f] == r.page_id) begin
        if (pins_q[f] < PIN_MAX) pins_q[f]++;
        refb_q[f] = 1'b1;
        o.frame = FrameW'(f);
        o.hit = 1'b1;
        return o;
      end
    end
    for (f = 0; f < NFRAMES; f++) begin
      if (!valid_q[f]) begin
        valid_q[f] = 1'b1; tag_q[f] = r.page_id; pins_q[f] = 8'd1;
        refb_q[f] = 1'b1; dirty_q[f] = 1'b0;
        o.frame = FrameW'(f);
        o.fetch_needed = 1'b1;
        return o;
      end
    end
    for (int s = 0; s < 2 * NFRAMES; s++) begin
      hand_q = hand_q + 1'b1;
      if (refb_q[hand_q]) begin
        refb_q[hand_q] = 1'b0;
      end else if (pins_q[hand_q] == 0) begin
        o.frame = hand_q;
        o.fetch_needed = 1'b1;
        o.writeback_needed = dirty_q[hand_q];
        o.evicted_page = tag_q[hand_q];
        tag_q[hand_q] = r.page_id; pins_q[hand_q] = 8'd1;
        refb_q[hand_q] = 1'b1; dirty_q[hand_q] = 1'b0;
        return o;
      end
    end
    o.status = STATUS_ALL_PINNED;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_GET;
      req_bus.page_id <= '0;
      req_bus.frame_index <= '0;
      req_bus.mark_dirty <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_rsps.push_back(predict_frame_grant(
          {req_bus.operation, req_bus.page_id, req_bus.frame_index, req_bus.mark_dirty}));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            (no_idle || $urandom_range(99) >= 28)) begin
          req_t n;
          n = pending_reqs.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.operation <= n.operation;
          req_bus.page_id <= n.page_id;
          req_bus.frame_index <= n.frame_index;
          req_bus.mark_dirty <= n.mark_dirty;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      rsp_bus.ready <= no_idle || ($urandom_range(99) >= 28);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected beat", 32'(rsp_bus.frame), '0);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_bus.frame !== e.frame)
            report_mismatch("frame", 32'(rsp_bus.frame), 32'(e.frame));
          if (rsp_bus.hit !== e.hit)
            report_mismatch("hit", 32'(rsp_bus.hit), 32'(e.hit));
          if (rsp_bus.fetch_needed !== e.fetch_needed)
            report_mismatch("fetch_needed", 32'(rsp_bus.fetch_needed),
                            32'(e.fetch_needed));
          if (rsp_bus.writeback_needed !== e.writeback_needed)
            report_mismatch("writeback_needed", 32'(rsp_bus.writeback_needed),
                            32'(e.writeback_needed));
          if (rsp_bus.evicted_page !== e.evicted_page)
            report_mismatch("evicted_page", rsp_bus.evicted_page, e.evicted_page);
          if (rsp_bus.status !== e.status)
            report_mismatch("status", 32'(rsp_bus.status), 32'(e.status));
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic req_t mk_get(logic [PageIdW-1:0] p);
    req_t r;
    r = '0;
    r.operation = OP_GET;
    r.page_id = p;
    r.frame_index = FrameW'($urandom);
    r.mark_dirty = 1'($urandom);
    return r;
  endfunction

  function automatic req_t mk_rel(logic [FrameW-1:0] f, logic d);
    req_t r;
    r = '0;
    r.operation = OP_RELEASE;
    r.page_id = $urandom;
    r.frame_index = f;
    r.mark_dirty = d;
    return r;
  endfunction

  task automatic drain_all();
    while (pending_reqs.size() > 0 || req_bus.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    errors = 0;
    hold_send = 0;
    no_idle = 0;
    hand_q = '0;
    for (int i = 0; i < NFRAMES; i++) begin
      tag_q[i] = '0; valid_q[i] = 0; refb_q[i] = 0; pins_q[i] = 0; dirty_q[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: release unused frames, fill all, all pinned, evictions
    pending_reqs.push_back(mk_rel(4'd0, 1'b1));
    pending_reqs.push_back(mk_rel(4'd15, 1'b0));
    pending_reqs.push_back(mk_get(32'h0000_0000));
    pending_reqs.push_back(mk_get(32'hFFFF_FFFF));
    pending_reqs.push_back(mk_get(32'h0000_0000));
    for (int i = 2; i < NFRAMES; i++) pending_reqs.push_back(mk_get(32'h100 + i));
    pending_reqs.push_back(mk_get(32'hDEAD_BEEF)); // every frame pinned
    pending_reqs.push_back(mk_rel(4'd1, 1'b1));
    pending_reqs.push_back(mk_rel(4'd3, 1'b0));
    pending_reqs.push_back(mk_get(32'hA5A5_5A5A)); // dirty writeback
    pending_reqs.push_back(mk_get(32'h5A5A_A5A5)); // clean eviction
    pending_reqs.push_back(mk_rel(4'd3, 1'b0));
    drain_all();

    // pin count saturation on frame 0
    for (int i = 0; i < 260; i++) pending_reqs.push_back(mk_get(32'h0000_0000));
    no_idle = 1;
    drain_all();
    no_idle = 0;
    for (int i = 0; i < 260; i++) pending_reqs.push_back(mk_rel(4'd0, i[0]));
    drain_all();

    // random: small working set, mostly balanced get/release
    for (int i = 0; i < 700; i++) begin
      if (i % 8 == 0)
        for (int k = 0; k < 8; k++)
          page_pool[k] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
      if (i == 300) no_idle = 1;
      if (i == 450) no_idle = 0;
      if (i == 500) begin
        // hold the sender until every outstanding beat has come back
        hold_send = 1;
        while (req_bus.valid || expected_rsps.size() > 0) @(posedge clk_i);
        hold_send = 0;
      end
      if ($urandom_range(99) < 50)
        pending_reqs.push_back(mk_get(page_pool[$urandom_range(7)]));
      else
        pending_reqs.push_back(mk_rel(FrameW'($urandom), 1'($urandom)));
      if (pending_reqs.size() > 20)
        while (pending_reqs.size() > 4) @(posedge clk_i);
    end
    drain_all();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cbpm_pkg.sv
sv/cbpm_if.sv
sv/cbpm_frame_mem.sv
sv/clock_buffer_pool_manager_top.sv
tb/tb_clock_buffer_pool_manager_top.sv
